FILE: rtl/bplc_pkg.sv
// shared types, constants and the level table of the button press level calibrator
package bplc_pkg;

    localparam int unsigned POINT_CAPACITY = 24;
    localparam int unsigned LEVEL_ENTRIES  = 13;

    localparam int unsigned CNT_W = $clog2(POINT_CAPACITY + 1);
    localparam int unsigned IDX_W = 4;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVED_WINDOW = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd25;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd800;
    localparam logic [CFG_W-1:0] SAVED_WINDOW_RESET = 16'd1500;

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(LEVEL_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(POINT_CAPACITY);

    typedef struct packed {
        logic        button_raw;
        logic [31:0] now_ms;
        logic [23:0] lux_reading;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  brightness_level;
        logic [4:0]  stored_count;
        logic        saved_event;
        logic [23:0] saved_lux;
        logic [7:0]  saved_level;
        logic        full_event;
        logic        level_stepped;
        logic        saved_window_active;
    } t_out_item;

    function automatic logic [7:0] level_of(input logic [IDX_W-1:0] idx);
        logic [7:0] lvl;
        unique case (idx)
            4'd0:    lvl = 8'd0;
            4'd1:    lvl = 8'd8;
            4'd2:    lvl = 8'd16;
            4'd3:    lvl = 8'd24;
            4'd4:    lvl = 8'd32;
            4'd5:    lvl = 8'd48;
            4'd6:    lvl = 8'd64;
            4'd7:    lvl = 8'd96;
            4'd8:    lvl = 8'd128;
            4'd9:    lvl = 8'd160;
            4'd10:   lvl = 8'd192;
            4'd11:   lvl = 8'd224;
            default: lvl = 8'd255;
        endcase
        return lvl;
    endfunction

endpackage

FILE: rtl/button_press_level_calibrator_top.sv
// top level of the button press level calibrator: debounce, press timing, level stepping, long-press saving
//
// usage
//   input channel: one item per button poll (raw level, ms timestamp, lux);
//   accepted when i_in_valid is high and o_in_stall is low
//   output channel: exactly one result item per input item, in order;
//   taken when o_out_valid is high and i_out_stall is low
//   configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
//   (0 debounce, 1 long press, 2 saved window, other indexes ignored)
//   path: an accepted item passes through the input register, then the result register
//   throughput: one item per cycle while the receiver does not stall; the state
//   update is combinational between the input register and the result register
//   reset: synchronous active low; clears all press, level, count and window
//   state, loads the register defaults and empties both stages
//   stall: when the receiver stalls, the result register holds; the input
//   register holds its item and o_in_stall rises in the same cycle, so no item
//   is lost or repeated
module button_press_level_calibrator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bplc_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bplc_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic [bplc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bplc_pkg::CFG_W-1:0]    i_cfg_data
);
    import bplc_pkg::*;

    logic [CFG_W-1:0] r_debounce, r_long_press, r_saved_window;

    logic       r_s1_vld;
    t_in_item   r_s1_item;
    logic       r_out_vld;
    t_out_item  r_out_item;

    logic             r_last_raw, n_last_raw;
    logic [31:0]      r_change_time, n_change_time;
    logic             r_press, n_press;
    logic [31:0]      r_press_start, n_press_start;
    logic             r_long_fired, n_long_fired;
    logic [IDX_W-1:0] r_level_idx, n_level_idx;
    logic [CNT_W-1:0] r_point_total, n_point_total;
    logic [31:0]      r_window_end, n_window_end;

    logic        out_free, adv;
    logic [31:0] since_change, since_press;
    logic        stable, down;
    logic        n_saved, n_full, n_stepped;
    t_out_item   n_out_item;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign adv         = r_s1_vld && out_free;
    assign o_in_stall  = r_s1_vld && !out_free;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    assign since_change = r_s1_item.now_ms - r_change_time;
    assign since_press  = r_s1_item.now_ms - r_press_start;
    assign stable       = since_change >= {16'd0, r_debounce};
    assign down         = !r_s1_item.button_raw;

    always_comb begin
        n_last_raw    = r_last_raw;
        n_change_time = r_change_time;
        n_press       = r_press;
        n_press_start = r_press_start;
        n_long_fired  = r_long_fired;
        n_level_idx   = r_level_idx;
        n_point_total = r_point_total;
        n_window_end  = r_window_end;
        n_saved       = 1'b0;
        n_full        = 1'b0;
        n_stepped     = 1'b0;
        if (r_s1_item.button_raw != r_last_raw) begin
            n_last_raw    = r_s1_item.button_raw;
            n_change_time = r_s1_item.now_ms;
        end else if (stable) begin
            if (down && !r_press) begin
                n_press       = 1'b1;
                n_press_start = r_s1_item.now_ms;
                n_long_fired  = 1'b0;
            end else if (down && r_press && !r_long_fired
                         && since_press >= {16'd0, r_long_press}) begin
                n_long_fired = 1'b1;
                if (r_point_total >= FULL_COUNT) begin
                    n_full = 1'b1;
                end else begin
                    n_saved       = 1'b1;
                    n_point_total = r_point_total + 1'b1;
                    n_window_end  = r_s1_item.now_ms + {16'd0, r_saved_window};
                end
            end else if (!down && r_press) begin
                n_press = 1'b0;
                if (!r_long_fired) begin
                    n_stepped   = 1'b1;
                    n_level_idx = (r_level_idx == LAST_INDEX) ? '0 : r_level_idx + 1'b1;
                end
            end
        end

        n_out_item.brightness_level    = level_of(n_level_idx);
        n_out_item.stored_count        = 5'(n_point_total);
        n_out_item.saved_event         = n_saved;
        n_out_item.saved_lux           = n_saved ? r_s1_item.lux_reading : 24'd0;
        n_out_item.saved_level         = n_saved ? level_of(r_level_idx) : 8'd0;
        n_out_item.full_event          = n_full;
        n_out_item.level_stepped       = n_stepped;
        n_out_item.saved_window_active = r_s1_item.now_ms < n_window_end;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce     <= DEBOUNCE_RESET;
            r_long_press   <= LONG_PRESS_RESET;
            r_saved_window <= SAVED_WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:     r_debounce     <= i_cfg_data;
                CFG_LONG_PRESS:   r_long_press   <= i_cfg_data;
                CFG_SAVED_WINDOW: r_saved_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_item <= i_in_item;
        end
    end

    // press state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b1;
            r_change_time <= '0;
            r_press       <= 1'b0;
            r_press_start <= '0;
            r_long_fired  <= 1'b0;
            r_level_idx   <= '0;
            r_point_total <= '0;
            r_window_end  <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (adv) begin
                r_last_raw    <= n_last_raw;
                r_change_time <= n_change_time;
                r_press       <= n_press;
                r_press_start <= n_press_start;
                r_long_fired  <= n_long_fired;
                r_level_idx   <= n_level_idx;
                r_point_total <= n_point_total;
                r_window_end  <= n_window_end;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item <= n_out_item;
        end
    end

`ifndef ASSERT_OFF
    a_save_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_item.saved_event && r_out_item.full_event))
        else $error("save and full reported together");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_point_total <= FULL_COUNT)
        else $error("point count above capacity");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level_idx <= LAST_INDEX)
        else $error("level index out of table");

    a_save_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_saved) |=> r_point_total == $past(r_point_total) + 1'b1)
        else $error("save without count increment");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_free) |=> r_s1_vld && $stable(r_level_idx)
                                    && $stable(r_point_total))
        else $error("state moved while stalled");
`endif

endmodule
